FILE: hw/rtl/lpht_pkg.sv
// -----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and helpers for the linear-probe hash table.
// -----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 64;
  localparam int RSP_W  = 2;

  // stream packing
  localparam int IN_TDATA_W  = KEY_W + VAL_W;  // key, value
  localparam int OUT_TUSER_W = RSP_W + 1;      // status, found
  localparam int OUT_TDATA_W = VAL_W;          // read_value

  // command codes; the unused code behaves as a lookup
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [RSP_W-1:0] {
    RSP_DONE      = 2'd0,
    RSP_PRESENT   = 2'd1,
    RSP_NOT_FOUND = 2'd2,
    RSP_FULL      = 2'd3
  } rsp_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PROBE,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction, set home slot
    logic read;    // issue the first slot read
    logic probe;   // examine the read slot, read the next one
    logic finish;  // update the table and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic probe_done;
    logic out_busy;
  } dp_sts_t;

  // home slot: magnitude of the key, modulo the table size
  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] mag;
    mag = k[KEY_W-1] ? (KEY_W'(0) - k) : k;
    return SLOT_W'(mag % SLOTS);
  endfunction

  // next probe position, wrapping round the table
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
    return (idx == SLOT_W'(SLOTS - 1)) ? '0 : idx + SLOT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lpht_ctrl.sv
// -----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer for one transaction: accept, read, probe loop, table update.
// -----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire lpht_pkg::dp_sts_t sts_i,
  output lpht_pkg::dp_cmd_t      cmd_o
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_dp.sv
// -----------------------------------------------------------------------------
// lpht_dp
// Slot storage, probe pointer, hit/free tracking and result register.
// -----------------------------------------------------------------------------
`default_nettype none

module lpht_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire lpht_pkg::dp_cmd_t                   cmd_i,
  output lpht_pkg::dp_sts_t                        sts_o,
  input  wire logic [lpht_pkg::CMD_W-1:0]          in_command_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]          in_key_i,
  input  wire logic [lpht_pkg::VAL_W-1:0]          in_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [lpht_pkg::RSP_W-1:0]               out_status_o,
  output logic                                     out_found_o,
  output logic [lpht_pkg::VAL_W-1:0]               out_value_o
);
  import lpht_pkg::*;

  // transaction registers
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  // probe state
  logic [SLOT_W-1:0] idx_q, rd_idx_q, cnt_q;
  slot_e             st_rd_q;
  logic [KEY_W-1:0]  key_rd_q;
  logic [VAL_W-1:0]  pay_rd_q;
  logic              hit_q, free_q;
  logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
  logic [VAL_W-1:0]  rv_q;

  // slot storage
  slot_e             slot_st_q [SLOTS];
  logic [KEY_W-1:0]  key_mem   [SLOTS];
  logic [VAL_W-1:0]  pay_mem   [SLOTS];

  // result register
  logic              out_valid_q;
  logic [RSP_W-1:0]  out_status_q;
  logic              out_found_q;
  logic [VAL_W-1:0]  out_value_q;

  logic              mem_re;
  logic              key_match, slot_empty;
  logic              key_we, pay_we, st_we;
  logic [SLOT_W-1:0] wr_idx;
  slot_e             st_wdata;
  logic [VAL_W-1:0]  pay_wdata;
  rsp_e              rsp;
  logic              found;
  logic [VAL_W-1:0]  rv;

  assign mem_re     = cmd_i.read | cmd_i.probe;
  assign slot_empty = (st_rd_q == SLOT_EMPTY);
  assign key_match  = (st_rd_q == SLOT_USED) && (key_rd_q == key_q);

  assign sts_o.probe_done = key_match | slot_empty | (cnt_q == SLOT_W'(SLOTS - 1));
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  // table update and result for the finishing transaction
  always_comb begin
    key_we    = 1'b0;
    pay_we    = 1'b0;
    st_we     = 1'b0;
    wr_idx    = free_idx_q;
    st_wdata  = SLOT_USED;
    pay_wdata = val_q;
    rsp       = RSP_DONE;
    found     = 1'b0;
    rv        = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (hit_q) begin
          rsp   = RSP_PRESENT;
          found = 1'b1;
        end else if (!free_q) begin
          rsp = RSP_FULL;
        end else begin
          key_we = cmd_i.finish;
          pay_we = cmd_i.finish;
          st_we  = cmd_i.finish;
        end
      end
      CMD_DELETE: begin
        wr_idx    = hit_idx_q;
        st_wdata  = SLOT_TOMB;
        pay_wdata = '0;
        if (hit_q) begin
          found  = 1'b1;
          pay_we = cmd_i.finish;
          st_we  = cmd_i.finish;
        end else begin
          rsp = RSP_NOT_FOUND;
        end
      end
      default: begin
        if (hit_q) begin
          found = 1'b1;
          rv    = rv_q;
        end else begin
          rsp = RSP_NOT_FOUND;
        end
      end
    endcase
  end

  // transaction capture and probe walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_command_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
      idx_q <= home_slot(in_key_i);
      cnt_q <= '0;
    end
    if (mem_re) begin
      st_rd_q  <= slot_st_q[idx_q];
      rd_idx_q <= idx_q;
      idx_q    <= next_slot(idx_q);
    end
    if (cmd_i.probe) begin
      cnt_q <= cnt_q + SLOT_W'(1);
      if (key_match) begin
        hit_idx_q <= rd_idx_q;
        rv_q      <= pay_rd_q;
      end
      if (!free_q && (slot_empty || st_rd_q == SLOT_TOMB)) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.probe) begin
      if (key_match) begin
        hit_q <= 1'b1;
      end
      if (slot_empty || st_rd_q == SLOT_TOMB) begin
        free_q <= 1'b1;
      end
    end
  end

  // slot states: cleared to empty by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_q[i] <= SLOT_EMPTY;
      end
    end else if (st_we) begin
      slot_st_q[wr_idx] <= st_wdata;
    end
  end

  // key and payload memories, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (pay_we) begin
      pay_mem[wr_idx] <= pay_wdata;
    end
    if (mem_re) begin
      key_rd_q <= key_mem[idx_q];
      pay_rd_q <= pay_mem[idx_q];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= rsp;
      out_found_q  <= found;
      out_value_q  <= rv;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_value_o  = out_value_q;

  // a successful insert leaves its slot occupied
  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && cmd_q == CMD_INSERT && !hit_q && free_q
    |=> slot_st_q[$past(free_idx_q)] == SLOT_USED)
    else $error("insert did not occupy the free slot");

  // a successful delete leaves a tombstone
  a_delete_tombs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && cmd_q == CMD_DELETE && hit_q
    |=> slot_st_q[$past(hit_idx_q)] == SLOT_TOMB)
    else $error("delete did not leave a tombstone");

  // a nonzero value only comes back from a found key with status done
  a_value_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_value_q != '0
    |-> out_found_q && out_status_q == RSP_DONE)
    else $error("value returned without a hit");

  // a found key never reports not-found or full
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q
    |-> out_status_q == RSP_DONE || out_status_q == RSP_PRESENT)
    else $error("found flag with a miss status");

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// -----------------------------------------------------------------------------
// linear_probe_hash_table
// Closed hash table with linear probing and tombstones, stream interface.
// -----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  s_axis   in         tvalid / tready        tuser: command; tdata: key, value
//  m_axis   out        tvalid / tready        tuser: status, found; tdata: read_value
//
//  Sequence: from accept to result, a transaction passes the first slot read,
//  a probe step per probed slot, the table update, and the result held in
//  the output register. The home slot is hashed as the transaction is
//  accepted. In the probe loop the key/payload memory delivers one slot per
//  cycle.
//  Reset: slot states are flip-flops cleared at once; no clearing pass.
//  Stalls: the result register holds an untaken result while the next
//  transaction is accepted and probed; the update waits until it is taken.
// -----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input transactions
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // [31:0] key, [95:32] value
  input  wire logic [lpht_pkg::CMD_W-1:0]          s_axis_tuser_i,  // [1:0] command
  // result transactions
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [lpht_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,  // [63:0] read_value
  output logic [lpht_pkg::OUT_TUSER_W-1:0]         m_axis_tuser_o   // [1:0] status, [2] found
);
  import lpht_pkg::*;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [RSP_W-1:0] out_status;
  logic             out_found;

  // sequence each transaction
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot storage, probe walk and result register
  lpht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_command_i (s_axis_tuser_i),
    .in_key_i     (s_axis_tdata_i[KEY_W-1:0]),
    .in_value_i   (s_axis_tdata_i[KEY_W +: VAL_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_found_o  (out_found),
    .out_value_o  (m_axis_tdata_o)
  );

  // pack status in the low bits, found above it
  assign m_axis_tuser_o = {out_found, out_status};

endmodule

`default_nettype wire

FILE: sim/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives insert, delete and lookup transactions into the hash table, keeps a
// shadow copy of the slot array to work out each status, found flag and
// payload, and compares every result transaction against it in order.
// -----------------------------------------------------------------------------

module linear_probe_hash_table_test;
  import lpht_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // decoded as a lookup
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int POOL_SIZE = 24;

  typedef struct {
    rsp_e             status;
    logic             found;
    logic [VAL_W-1:0] read_value;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // shadow of the slot array
  slot_e            shadow_state [SLOTS];
  logic [KEY_W-1:0] shadow_key   [SLOTS];
  logic [VAL_W-1:0] shadow_value [SLOTS];

  outcome_t outcome_q [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  // long receiver hold-off: the test bumps the id, the receiver counts it out
  int rx_hold_id = 0;
  int rx_hold_len = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  linear_probe_hash_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [31:0] key, [95:32] value
    .s_axis_tuser_i  (s_axis_tuser),   // [1:0] command
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),   // [63:0] read_value
    .m_axis_tuser_o  (m_axis_tuser)    // [1:0] status, [2] found
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Search the shadow table for one key, apply the command, return the outcome.
  function automatic outcome_t table_apply(input logic [CMD_W-1:0] cmd,
                                           input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val);
    outcome_t         res;
    logic [KEY_W-1:0] magnitude;
    int unsigned      idx;
    int               hit;
    int               free_at;
    bit               stop;
    res.status = RSP_DONE;
    res.found = 1'b0;
    res.read_value = '0;
    magnitude = key[KEY_W-1] ? (~key + 1'b1) : key;
    idx = magnitude % SLOTS;
    hit = -1;
    free_at = -1;
    stop = 1'b0;
    // bounded linear probe: stop on an empty slot or on the key itself
    for (int n = 0; n < SLOTS && !stop; n++) begin
      if (shadow_state[idx] == SLOT_EMPTY) begin
        if (free_at < 0) free_at = idx;
        stop = 1'b1;
      end else if (shadow_state[idx] == SLOT_TOMB) begin
        if (free_at < 0) free_at = idx;
      end else if (shadow_key[idx] == key) begin
        hit = idx;
        stop = 1'b1;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (cmd == CMD_INSERT) begin
      if (hit >= 0) begin
        res.status = RSP_PRESENT;
        res.found = 1'b1;
      end else if (free_at < 0) begin
        res.status = RSP_FULL;
      end else begin
        shadow_state[free_at] = SLOT_USED;
        shadow_key[free_at] = key;
        shadow_value[free_at] = val;
      end
    end else if (cmd == CMD_DELETE) begin
      if (hit >= 0) begin
        shadow_state[hit] = SLOT_TOMB;
        shadow_value[hit] = '0;
        res.found = 1'b1;
      end else begin
        res.status = RSP_NOT_FOUND;
      end
    end else begin
      // lookup, and the unused code behaves the same way
      if (hit >= 0) begin
        res.found = 1'b1;
        res.read_value = shadow_value[hit];
      end else begin
        res.status = RSP_NOT_FOUND;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("ERROR at cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("result with nothing pending", m_axis_tdata, '0);
    end else begin
      want = outcome_q.pop_front();
      if (m_axis_tuser[RSP_W-1:0] !== want.status)
        report_mismatch("status", VAL_W'(m_axis_tuser[RSP_W-1:0]), VAL_W'(want.status));
      if (m_axis_tuser[RSP_W] !== want.found)
        report_mismatch("found", VAL_W'(m_axis_tuser[RSP_W]), VAL_W'(want.found));
      if (m_axis_tdata !== want.read_value)
        report_mismatch("read_value", m_axis_tdata, want.read_value);
    end
  endtask

  // Receiver: check every result transaction, then pick the next tready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_outcome();
    if (rx_hold_seen != rx_hold_id) begin
      rx_hold_seen <= rx_hold_id;
      rx_hold_left <= rx_hold_len;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run with a mismatch once the cycle limit is passed.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_probe_hash_table: mismatch");
      $finish;
    end
  end

  // Offer one transaction, with random idle cycles ahead of it, and hold it
  // until accepted. Returns at the accepting edge with tvalid still high.
  task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, key};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    outcome_q.push_back(table_apply(cmd, key, val));
  endtask

  // Pause the sender until every pending result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // Edge keys, collisions at slot 0, wrap from slot 15, tombstones, odd code.
  task automatic test_directed();
    send_op(CMD_LOOKUP, 32'd0, '0);
    send_op(CMD_DELETE, 32'd5, '0);
    send_op(CMD_INSERT, 32'd0, '1);
    send_op(CMD_INSERT, 32'd16, '0);
    send_op(CMD_INSERT, 32'h8000_0000, rand_value());   // magnitude 2^31, home 0
    send_op(CMD_INSERT, 32'h7fff_ffff, rand_value());   // home 15
    send_op(CMD_INSERT, 32'h8000_0001, rand_value());   // home 15, wraps to 3
    send_op(CMD_INSERT, 32'd0, rand_value());           // present: payload kept
    send_op(CMD_LOOKUP, 32'd0, rand_value());
    send_op(CMD_DELETE, 32'd16, rand_value());
    send_op(CMD_INSERT, 32'h8000_0000, rand_value());   // found past the tombstone
    send_op(CMD_LOOKUP, 32'h8000_0000, '0);
    send_op(CMD_INSERT, 32'd32, rand_value());          // reuses the tombstone
    send_op(CMD_UNUSED, 32'd32, '0);
    send_op(CMD_LOOKUP, 32'd16, '0);
    send_op(CMD_DELETE, 32'h8000_0001, '0);
    send_op(CMD_LOOKUP, 32'h7fff_ffff, '0);
    send_op(CMD_DELETE, 32'd0, '0);
    send_op(CMD_DELETE, 32'd32, '0);
    send_op(CMD_DELETE, 32'h8000_0000, '0);
    send_op(CMD_DELETE, 32'h7fff_ffff, '0);
    send_op(CMD_LOOKUP, 32'd0, '0);
    drain();
  endtask

  // Fill every slot, probe the full table, then empty it again.
  task automatic test_full_table();
    logic [KEY_W-1:0] fill_key [SLOTS + 2];
    logic [KEY_W-1:0] extra_key;
    for (int j = 0; j < SLOTS + 2; j++) begin
      fill_key[j] = {27'($urandom_range(32'h07ff_ffff, 0)), 5'(j)};
      send_op(CMD_INSERT, fill_key[j], rand_value());
    end
    extra_key = {27'($urandom), 5'h1f} ^ 32'h0000_0020;
    send_op(CMD_LOOKUP, extra_key, '0);                 // absent, no empty slot
    send_op(CMD_INSERT, fill_key[3], rand_value());
    send_op(CMD_DELETE, fill_key[5], '0);
    send_op(CMD_INSERT, extra_key, rand_value());       // lands in the tombstone
    send_op(CMD_INSERT, fill_key[5], rand_value());     // full again
    send_op(CMD_LOOKUP, extra_key, '0);
    for (int j = 0; j < SLOTS + 2; j++) send_op(CMD_DELETE, fill_key[j], '0);
    send_op(CMD_DELETE, extra_key, '0);
    drain();
  endtask

  // Build a fresh key pool: edge keys plus clustered and spread random keys.
  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i)
        0: key_pool[i] = 32'd0;
        1: key_pool[i] = 32'h7fff_ffff;
        2: key_pool[i] = 32'h8000_0000;
        3: key_pool[i] = 32'h8000_0001;
        4: key_pool[i] = 32'hffff_ffff;
        default: begin
          if (i % 2 == 1) key_pool[i] = $urandom;
          else key_pool[i] = ($urandom & ~32'h0000_000f) | 32'(i % 3);
        end
      endcase
    end
  endtask

  task automatic random_op();
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_INSERT;
    else if (pick < 65) cmd = CMD_DELETE;
    else if (pick < 95) cmd = CMD_LOOKUP;
    else cmd = CMD_UNUSED;
    if ($urandom_range(9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(POOL_SIZE - 1)];
    send_op(cmd, key, rand_value());
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    refill_pool();
    for (int i = 0; i < count; i++) begin
      random_op();
      // now and then let the pipeline run dry so gaps hit every phase
      if ($urandom_range(49) == 0) drain();
    end
    drain();
  endtask

  // Stall the result side for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    rx_hold_len <= 300;
    rx_hold_id <= rx_hold_id + 1;
    for (int i = 0; i < 20; i++) random_op();
    drain();
  endtask

  initial begin
    // the table comes out of reset with every slot empty
    for (int i = 0; i < SLOTS; i++) shadow_state[i] = SLOT_EMPTY;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_traffic(190, 13, 53);
    test_random_traffic(190, 53, 13);
    test_output_backpressure();
    test_random_traffic(190, 0, 0);
    // let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("linear_probe_hash_table: match");
    end else begin
      $display("linear_probe_hash_table: mismatch");
    end
    $finish;
  end

endmodule
